### src/three_axis_rc_lowpass_top_assert.svh
// assertion macros shared by the rc low-pass rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef THREE_AXIS_RC_LOWPASS_TOP_ASSERT_SVH
`define THREE_AXIS_RC_LOWPASS_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define RCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define RCL_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### src/rcl_pkg.sv
// shared widths, types and constants for the three-axis rc low-pass filter
// no dependencies
`timescale 1ns / 1ps

package rcl_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STEP_W   = 24;
  localparam int RC_W     = 24;
  localparam int CFG_W    = RC_W;
  localparam int CFG_IDX_W = 1;
  localparam int DT_W     = STEP_W - 1;
  localparam int DEN_W    = RC_W + 1;
  localparam int FRAC     = 16;
  localparam int ALPHA_W  = FRAC + 1;
  localparam int CNT_W    = $clog2(ALPHA_W);
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = ALPHA_W + 1 + DIFF_W;
  localparam int AXES     = 3;
  localparam int AXIS_W   = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {FRAC{1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE = 1'b0,
    CFG_TIME_CONSTANT = 1'b1
  } cfg_reg_e;

endpackage

### src/rcl_div.sv
// radix-2 restoring divider producing the filter gain dt*2^frac/(dt+rc)
// depends on rcl_pkg
`timescale 1ns / 1ps

module rcl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rcl_pkg::DT_W-1:0]    dt_i,
  input  logic [rcl_pkg::DEN_W-1:0]   den_i,
  output rcl_pkg::div_status_t        status_o,
  output logic [rcl_pkg::ALPHA_W-1:0] quot_o
);
  import rcl_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [ALPHA_W-1:0] num_q, num_d;
  logic [ALPHA_W-1:0] quot_q, quot_d;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               qbit;

  // quotient never exceeds 2^frac, so the division starts with dt>>1 already below den
  assign trial = {rem_q, num_q[ALPHA_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DEN_W'(dt_i >> 1);
      den_d  = den_i;
      num_d  = {dt_i[0], {FRAC{1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_d  = {num_q[ALPHA_W-2:0], 1'b0};
      quot_d = {quot_q[ALPHA_W-2:0], qbit};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ALPHA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

### src/rcl_blend.sv
// shared blend unit: registered alpha*(x-y) product, then y + (product >>> frac)
// depends on rcl_pkg
`timescale 1ns / 1ps

module rcl_blend (
  input  logic                        clk_i,
  input  logic                        mul_en_i,
  input  logic [rcl_pkg::ALPHA_W-1:0] alpha_i,
  input  rcl_pkg::sample_t            x_i,
  input  rcl_pkg::sample_t            y_i,
  output rcl_pkg::sample_t            res_o
);
  import rcl_pkg::*;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_sh;

  assign diff    = DIFF_W'(x_i) - DIFF_W'(y_i);
  assign alpha_s = {1'b0, alpha_i};
  assign prod_d  = PROD_W'(alpha_s) * PROD_W'(diff);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // alpha is at most one, so y plus the scaled step always fits the sample width
  assign prod_sh = prod_q >>> FRAC;
  assign res_o   = y_i + prod_sh[SAMPLE_W-1:0];

endmodule

### src/three_axis_rc_lowpass_top.sv
// a filtered item runs the divider in ST_DIV, then ST_MUL and ST_ADD per axis, then ST_FINISH
// the gain comes from a 17-step radix-2 divider, then one shared multiplier blends
// the three axes in turn (ST_MUL then ST_ADD for each); with step and time constant
// both zero the divider is skipped; pass-through items go straight to ST_FINISH
// one transaction in flight; the output register lets a new item in while a result waits
// reset clears the configuration, the filter state and the control, no clearing pass
`timescale 1ns / 1ps

module three_axis_rc_lowpass_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [rcl_pkg::SAMPLE_W-1:0] axis_x_i,
  input  logic signed [rcl_pkg::SAMPLE_W-1:0] axis_y_i,
  input  logic signed [rcl_pkg::SAMPLE_W-1:0] axis_z_i,
  input  logic signed [rcl_pkg::STEP_W-1:0]   step_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [rcl_pkg::SAMPLE_W-1:0] out_x_o,
  output logic signed [rcl_pkg::SAMPLE_W-1:0] out_y_o,
  output logic signed [rcl_pkg::SAMPLE_W-1:0] out_z_o,
  output logic                          filtered_o
);
  import rcl_pkg::*;
  `include "three_axis_rc_lowpass_top_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_ADD    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic               en_q;
  logic [RC_W-1:0]    rc_q;
  logic [AXIS_W-1:0]  axis_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic               filt_q;
  sample_t            sample_q [AXES];
  sample_t            filter_q [AXES];
  logic               out_valid_q;
  sample_t            out_x_q, out_y_q, out_z_q;
  logic               out_filt_q;

  logic               in_acc;
  logic               apply;
  logic [DT_W-1:0]    dt;
  logic [DEN_W-1:0]   den;
  logic               den_zero;
  logic               div_start;
  div_status_t        div_st;
  logic [ALPHA_W-1:0] div_quot;
  sample_t            blend_res;
  logic               out_load;
  logic               last_axis;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign apply     = en_q && !step_us_i[STEP_W-1];
  assign dt        = step_us_i[DT_W-1:0];
  assign den       = DEN_W'(dt) + DEN_W'(rc_q);
  assign den_zero  = (den == '0);
  assign div_start = in_acc && apply && !den_zero;
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign last_axis = (axis_q == AXIS_W'(AXES - 1));

  rcl_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dt_i     (dt),
    .den_i    (den),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  rcl_blend u_blend (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .alpha_i  (alpha_q),
    .x_i      (sample_q[axis_q]),
    .y_i      (filter_q[axis_q]),
    .res_o    (blend_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!apply) begin
            state_d = ST_FINISH;
          end else if (den_zero) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = last_axis ? ST_FINISH : ST_MUL;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      rc_q        <= '0;
      axis_q      <= '0;
      filt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        filter_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILTER_ENABLE: en_q <= cfg_data_i[0];
          CFG_TIME_CONSTANT: rc_q <= cfg_data_i[RC_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        axis_q <= '0;
        filt_q <= apply;
        if (!apply) begin
          filter_q[0] <= axis_x_i;
          filter_q[1] <= axis_y_i;
          filter_q[2] <= axis_z_i;
        end
      end
      if (state_q == ST_ADD) begin
        filter_q[axis_q] <= blend_res;
        axis_q           <= axis_q + AXIS_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q[0] <= axis_x_i;
      sample_q[1] <= axis_y_i;
      sample_q[2] <= axis_z_i;
      if (den_zero) begin
        alpha_q <= ALPHA_ONE;
      end
    end
    if ((state_q == ST_DIV) && div_st.done) begin
      alpha_q <= div_quot;
    end
    if (out_load) begin
      out_x_q    <= filter_q[0];
      out_y_q    <= filter_q[1];
      out_z_q    <= filter_q[2];
      out_filt_q <= filt_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign filtered_o  = out_filt_q;

  `RCL_ASSERT(a_div_done_in_div, div_st.done |-> (state_q == ST_DIV), "divider done outside div")
  `RCL_ASSERT(a_alpha_le_one, (state_q == ST_MUL) |-> (alpha_q <= ALPHA_ONE), "gain above one")
  `RCL_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "early result")
  `RCL_ASSERT_NEVER(a_div_busy_idle, div_st.busy && (state_q == ST_IDLE), "divider busy while idle")

endmodule
